// ===== sv/blle_pkg.sv =====
// package: sizes, request codes and status codes of the linked list engine
package blle_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_DELETE     = 3'd4,
    OP_QUERY      = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

endpackage

// ===== sv/bounded_linked_list_engine_core.sv =====
// linked list engine: list in value and link memories, free list, one walk step per cycle
// early rejects (full, empty, no match on empty list, unknown code) strobe the cycle
// after the start beat; push and pop front strobe from S_FIRST; pop back of more than two
// entries walks in S_WALK to the entry before the tail; delete and query scan in S_SCAN up
// to the match, and a match past the head is freed in S_FREE. a new beat is taken once busy drops.
// the link walk is bound by one registered memory read per cycle. reset clears the list at
// once: per-entry valid bits stand for the reset links, so there is no clearing pass.
module bounded_linked_list_engine_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [2:0]                          req_type_i,
  input  logic signed [blle_pkg::VAL_W-1:0]   value_i,
  output logic                                result_valid_o,
  output logic signed [blle_pkg::VAL_W-1:0]   result_value_o,
  output logic                                found_o,
  output logic [1:0]                          status_o,
  output logic [blle_pkg::CNT_W-1:0]          count_o
);

  localparam int IW = blle_pkg::IDX_W;
  localparam int CW = blle_pkg::CNT_W;
  localparam int VW = blle_pkg::VAL_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIRST,
    S_WALK,
    S_SCAN,
    S_FREE
  } state_e;

  state_e state_q, state_d;
  logic [2:0]           op_q, op_d;
  logic signed [VW-1:0] val_q, val_d;
  logic [IW-1:0]        head_q, head_d, tail_q, tail_d, free_q, free_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [IW-1:0]        cur_q, cur_d, pred_q, pred_d, node_q, node_d;
  logic [IW-1:0]        k_q, k_d, steps_q, steps_d;
  logic                 rvalid_q, rvalid_d, found_q, found_d;
  logic signed [VW-1:0] rvalue_q, rvalue_d;
  logic [1:0]           status_q, status_d;

  // memories
  logic signed [VW-1:0] value_mem [blle_pkg::CAPACITY];
  logic [IW-1:0]        link_mem  [blle_pkg::CAPACITY];
  logic                 link_vld_q [blle_pkg::CAPACITY];

  logic [IW-1:0]        rd_addr;
  logic signed [VW-1:0] value_rd_q;
  logic [IW-1:0]        link_rd_q, link_def_q;
  logic                 link_vld_rd_q;
  logic [IW-1:0]        link_data;

  logic                 lk_we, vl_we;
  logic [IW-1:0]        lk_wa, lk_wd, vl_wa;

  // unwritten links read as the reset chain
  assign link_data = link_vld_rd_q ? link_rd_q : link_def_q;

  always_ff @(posedge clk_i) begin
    value_rd_q <= value_mem[rd_addr];
    link_rd_q  <= link_mem[rd_addr];
    link_def_q <= (rd_addr == IW'(blle_pkg::CAPACITY - 1)) ? '0 : rd_addr + 1'b1;
    if (vl_we) begin
      value_mem[vl_wa] <= val_q;
    end
    if (lk_we) begin
      link_mem[lk_wa] <= lk_wd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < blle_pkg::CAPACITY; i++) begin
        link_vld_q[i] <= 1'b0;
      end
      link_vld_rd_q <= 1'b0;
    end else begin
      link_vld_rd_q <= link_vld_q[rd_addr];
      if (lk_we) begin
        link_vld_q[lk_wa] <= 1'b1;
      end
    end
  end

  // read address: start point in idle, then follow the link just read
  always_comb begin
    rd_addr = head_q;
    case (state_q)
      S_IDLE: begin
        case (req_type_i)
          blle_pkg::OP_PUSH_FRONT, blle_pkg::OP_PUSH_BACK: rd_addr = free_q;
          blle_pkg::OP_POP_BACK:                           rd_addr = tail_q;
          default:                                         rd_addr = head_q;
        endcase
      end
      S_FIRST: rd_addr = head_q;
      S_WALK:  rd_addr = link_data;
      S_SCAN:  rd_addr = link_data;
      S_FREE:  rd_addr = cur_q;
      default: rd_addr = head_q;
    endcase
  end

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    val_d    = val_q;
    head_d   = head_q;
    tail_d   = tail_q;
    free_d   = free_q;
    cnt_d    = cnt_q;
    cur_d    = cur_q;
    pred_d   = pred_q;
    node_d   = node_q;
    k_d      = k_q;
    steps_d  = steps_q;
    rvalid_d = 1'b0;
    rvalue_d = rvalue_q;
    found_d  = found_q;
    status_d = status_q;
    lk_we    = 1'b0;
    lk_wa    = '0;
    lk_wd    = '0;
    vl_we    = 1'b0;
    vl_wa    = '0;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          op_d     = req_type_i;
          val_d    = value_i;
          rvalue_d = '0;
          found_d  = 1'b0;
          status_d = blle_pkg::ST_OK;
          cur_d    = head_q;
          pred_d   = head_q;
          k_d      = '0;
          case (req_type_i)
            blle_pkg::OP_PUSH_FRONT, blle_pkg::OP_PUSH_BACK: begin
              if (cnt_q == CW'(blle_pkg::CAPACITY)) begin
                status_d = blle_pkg::ST_FULL;
                rvalid_d = 1'b1;
              end else begin
                state_d = S_FIRST;
              end
            end
            blle_pkg::OP_POP_FRONT, blle_pkg::OP_POP_BACK: begin
              if (cnt_q == '0) begin
                status_d = blle_pkg::ST_EMPTY;
                rvalid_d = 1'b1;
              end else begin
                state_d = S_FIRST;
              end
            end
            blle_pkg::OP_DELETE, blle_pkg::OP_QUERY: begin
              if (cnt_q == '0) begin
                status_d = blle_pkg::ST_NOT_FOUND;
                rvalid_d = 1'b1;
              end else begin
                state_d = S_SCAN;
              end
            end
            default: begin
              rvalid_d = 1'b1;
            end
          endcase
        end
      end

      S_FIRST: begin
        case (op_q)
          blle_pkg::OP_PUSH_FRONT, blle_pkg::OP_PUSH_BACK: begin
            // link_data is the successor of the free head
            vl_we  = 1'b1;
            vl_wa  = free_q;
            free_d = link_data;
            if (cnt_q == '0) begin
              head_d = free_q;
              tail_d = free_q;
            end else if (op_q == blle_pkg::OP_PUSH_FRONT) begin
              lk_we  = 1'b1;
              lk_wa  = free_q;
              lk_wd  = head_q;
              head_d = free_q;
            end else begin
              lk_we  = 1'b1;
              lk_wa  = tail_q;
              lk_wd  = free_q;
              tail_d = free_q;
            end
            cnt_d    = cnt_q + 1'b1;
            rvalid_d = 1'b1;
            state_d  = S_IDLE;
          end
          blle_pkg::OP_POP_FRONT: begin
            rvalue_d = value_rd_q;
            head_d   = link_data;
            lk_we    = 1'b1;
            lk_wa    = head_q;
            lk_wd    = free_q;
            free_d   = head_q;
            cnt_d    = cnt_q - 1'b1;
            rvalid_d = 1'b1;
            state_d  = S_IDLE;
          end
          default: begin
            // pop back: find the entry before the tail
            rvalue_d = value_rd_q;
            node_d   = tail_q;
            if (cnt_q > CW'(2)) begin
              steps_d = IW'(cnt_q - CW'(2));
              state_d = S_WALK;
            end else begin
              if (cnt_q == CW'(2)) begin
                tail_d = head_q;
              end
              lk_we    = 1'b1;
              lk_wa    = tail_q;
              lk_wd    = free_q;
              free_d   = tail_q;
              cnt_d    = cnt_q - 1'b1;
              rvalid_d = 1'b1;
              state_d  = S_IDLE;
            end
          end
        endcase
      end

      S_WALK: begin
        if (steps_q == IW'(1)) begin
          tail_d   = link_data;
          lk_we    = 1'b1;
          lk_wa    = node_q;
          lk_wd    = free_q;
          free_d   = node_q;
          cnt_d    = cnt_q - 1'b1;
          rvalid_d = 1'b1;
          state_d  = S_IDLE;
        end else begin
          steps_d = steps_q - 1'b1;
        end
      end

      S_SCAN: begin
        if (value_rd_q == val_q) begin
          found_d  = 1'b1;
          status_d = blle_pkg::ST_OK;
          if (op_q == blle_pkg::OP_DELETE) begin
            if (k_q == '0) begin
              head_d   = link_data;
              lk_we    = 1'b1;
              lk_wa    = cur_q;
              lk_wd    = free_q;
              free_d   = cur_q;
              cnt_d    = cnt_q - 1'b1;
              rvalid_d = 1'b1;
              state_d  = S_IDLE;
            end else begin
              // bypass the match, then free it next cycle
              lk_we = 1'b1;
              lk_wa = pred_q;
              lk_wd = link_data;
              if (CW'(k_q) + CW'(1) == cnt_q) begin
                tail_d = pred_q;
              end
              state_d = S_FREE;
            end
          end else begin
            rvalid_d = 1'b1;
            state_d  = S_IDLE;
          end
        end else if (CW'(k_q) + CW'(1) == cnt_q) begin
          status_d = blle_pkg::ST_NOT_FOUND;
          rvalid_d = 1'b1;
          state_d  = S_IDLE;
        end else begin
          pred_d = cur_q;
          cur_d  = link_data;
          k_d    = k_q + 1'b1;
        end
      end

      S_FREE: begin
        lk_we    = 1'b1;
        lk_wa    = cur_q;
        lk_wd    = free_q;
        free_d   = cur_q;
        cnt_d    = cnt_q - 1'b1;
        rvalid_d = 1'b1;
        state_d  = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      head_q   <= '0;
      tail_q   <= '0;
      free_q   <= '0;
      cnt_q    <= '0;
      rvalid_q <= 1'b0;
      rvalue_q <= '0;
      found_q  <= 1'b0;
      status_q <= blle_pkg::ST_OK;
      op_q     <= '0;
      k_q      <= '0;
      steps_q  <= '0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      free_q   <= free_d;
      cnt_q    <= cnt_d;
      rvalid_q <= rvalid_d;
      rvalue_q <= rvalue_d;
      found_q  <= found_d;
      status_q <= status_d;
      op_q     <= op_d;
      k_q      <= k_d;
      steps_q  <= steps_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q    <= val_d;
    cur_q    <= cur_d;
    pred_q   <= pred_d;
    node_q   <= node_d;
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = rvalid_q;
  assign result_value_o = rvalue_q;
  assign found_o        = found_q;
  assign status_o       = status_q;
  assign count_o        = cnt_q;

endmodule

// ===== verif/tb_bounded_linked_list_engine_core.sv =====
`timescale 1ns / 100ps
// testbench for the linked list engine: directed and random requests, queue-based scoreboard

class list_tracker;
  typedef struct {
    logic signed [blle_pkg::VAL_W-1:0] value;
    logic                              found;
    logic [1:0]                        status;
    logic [blle_pkg::CNT_W-1:0]        count;
  } outcome_t;

  // list contents in order, head first
  logic signed [blle_pkg::VAL_W-1:0] entries[$];
  outcome_t                          outstanding[$];
  int                                mismatches;

  function new();
    mismatches = 0;
  endfunction

  function void note_request(logic [2:0] code, logic signed [blle_pkg::VAL_W-1:0] v);
    outcome_t o;
    int       hit;
    o.value  = '0;
    o.found  = 1'b0;
    o.status = blle_pkg::ST_OK;
    hit      = -1;
    case (code)
      blle_pkg::OP_PUSH_FRONT, blle_pkg::OP_PUSH_BACK: begin
        if (entries.size() >= blle_pkg::CAPACITY) o.status = blle_pkg::ST_FULL;
        else if (code == blle_pkg::OP_PUSH_FRONT) entries.push_front(v);
        else entries.push_back(v);
      end
      blle_pkg::OP_POP_FRONT: begin
        if (entries.size() == 0) o.status = blle_pkg::ST_EMPTY;
        else o.value = entries.pop_front();
      end
      blle_pkg::OP_POP_BACK: begin
        if (entries.size() == 0) o.status = blle_pkg::ST_EMPTY;
        else o.value = entries.pop_back();
      end
      blle_pkg::OP_DELETE, blle_pkg::OP_QUERY: begin
        // first match from the head wins
        foreach (entries[i]) if (hit < 0 && entries[i] == v) hit = i;
        if (hit < 0) begin
          o.status = blle_pkg::ST_NOT_FOUND;
        end else begin
          o.found = 1'b1;
          if (code == blle_pkg::OP_DELETE) entries.delete(hit);
        end
      end
      default: ;
    endcase
    o.count = blle_pkg::CNT_W'(entries.size());
    outstanding.push_back(o);
  endfunction

  function void check_result(logic signed [blle_pkg::VAL_W-1:0] v, logic f, logic [1:0] s,
                             logic [blle_pkg::CNT_W-1:0] c);
    outcome_t o;
    if (outstanding.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result beat with nothing pending: value %0d found %0d status %0d count %0d",
                 v, f, s, c);
      return;
    end
    o = outstanding.pop_front();
    if (v !== o.value || f !== o.found || s !== o.status || c !== o.count) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch: expected value %0d found %0d status %0d count %0d",
                 o.value, o.found, o.status, o.count);
        $display("          got value %0d found %0d status %0d count %0d", v, f, s, c);
      end
    end
  endfunction
endclass

module tb_bounded_linked_list_engine_core;

  localparam int          CLK_HALF       = 5;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          DRAIN_CYCLES   = 80;
  localparam int          PHASES         = 12;
  localparam int          PHASE_ITEMS    = 100;
  localparam logic [2:0]  OP_UNUSED_LO   = 3'd6;
  localparam logic [2:0]  OP_UNUSED_HI   = 3'd7;

  logic                               clk_i      = 1'b0;
  logic                               rst_ni     = 1'b0;
  logic                               start      = 1'b0;
  logic                               busy;
  logic [2:0]                         req_type_i = 3'd0;
  logic signed [blle_pkg::VAL_W-1:0]  value_i    = '0;
  logic                               result_valid_o;
  logic signed [blle_pkg::VAL_W-1:0]  result_value_o;
  logic                               found_o;
  logic [1:0]                         status_o;
  logic [blle_pkg::CNT_W-1:0]         count_o;

  list_tracker tracker = new();
  bit          gaps_on = 1'b1;
  int          stall_cycles = 0;

  always #CLK_HALF clk_i = ~clk_i;

  bounded_linked_list_engine_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_type_i     (req_type_i),
    .value_i        (value_i),
    .result_valid_o (result_valid_o),
    .result_value_o (result_value_o),
    .found_o        (found_o),
    .status_o       (status_o),
    .count_o        (count_o)
  );

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o)
      tracker.check_result(result_value_o, found_o, status_o, count_o);
  end

  // cycles with no beat on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic issue_request(logic [2:0] code, logic signed [blle_pkg::VAL_W-1:0] v);
    @(negedge clk_i);
    start      <= 1'b1;
    req_type_i <= code;
    value_i    <= v;
    do @(posedge clk_i); while (busy);
    tracker.note_request(code, v);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        @(negedge clk_i);
        start   <= 1'b0;
        value_i <= $urandom;
      end
    end
  endtask

  task automatic wait_all_results();
    @(negedge clk_i);
    start <= 1'b0;
    while (tracker.outstanding.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [blle_pkg::VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    // a narrow pool gives duplicates and matches
    if (r < 5) return $urandom_range(0, 31) - 16;
    if (r < 9) return $urandom;
    case ($urandom_range(0, 3))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2:       return 0;
      default: return -1;
    endcase
  endfunction

  function automatic logic signed [blle_pkg::VAL_W-1:0] pick_target();
    if (tracker.entries.size() != 0 && $urandom_range(0, 9) < 7)
      return tracker.entries[$urandom_range(0, tracker.entries.size() - 1)];
    return pick_value();
  endfunction

  // mode 0 grows the list, 1 shrinks it, 2 keeps it balanced
  task automatic random_request(int mode);
    int                                 r;
    int                                 push_pct;
    int                                 pop_pct;
    logic [2:0]                         code;
    logic signed [blle_pkg::VAL_W-1:0]  v;
    r        = $urandom_range(0, 99);
    push_pct = (mode == 0) ? 55 : (mode == 1) ? 20 : 38;
    pop_pct  = (mode == 1) ? 40 : 20;
    if (r < push_pct) begin
      code = $urandom_range(0, 1) ? blle_pkg::OP_PUSH_BACK : blle_pkg::OP_PUSH_FRONT;
      v    = pick_value();
    end else if (r < push_pct + pop_pct) begin
      code = $urandom_range(0, 1) ? blle_pkg::OP_POP_BACK : blle_pkg::OP_POP_FRONT;
      v    = $urandom;
    end else if (r < 99) begin
      code = $urandom_range(0, 1) ? blle_pkg::OP_DELETE : blle_pkg::OP_QUERY;
      v    = pick_target();
    end else begin
      code = $urandom_range(0, 1) ? OP_UNUSED_HI : OP_UNUSED_LO;
      v    = $urandom;
    end
    issue_request(code, v);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty list, unused codes
    issue_request(blle_pkg::OP_POP_FRONT, 32'sd5);
    issue_request(blle_pkg::OP_POP_BACK, -32'sd5);
    issue_request(blle_pkg::OP_DELETE, 32'sd5);
    issue_request(blle_pkg::OP_QUERY, 32'sd5);
    issue_request(OP_UNUSED_LO, $urandom);
    issue_request(OP_UNUSED_HI, $urandom);
    // push back on empty, popping the last entry
    issue_request(blle_pkg::OP_PUSH_BACK, 32'sh80000000);
    issue_request(blle_pkg::OP_POP_BACK, 32'sd0);
    issue_request(blle_pkg::OP_PUSH_FRONT, 32'sh7fffffff);
    issue_request(blle_pkg::OP_POP_FRONT, 32'sd0);
    issue_request(blle_pkg::OP_PUSH_BACK, 32'sd0);
    issue_request(blle_pkg::OP_PUSH_BACK, -32'sd1);
    issue_request(blle_pkg::OP_PUSH_FRONT, 32'sd7);
    issue_request(blle_pkg::OP_PUSH_BACK, 32'sd7);
    issue_request(blle_pkg::OP_PUSH_BACK, 32'sd3);
    // search and delete at head, middle and tail
    issue_request(blle_pkg::OP_QUERY, 32'sd7);
    issue_request(blle_pkg::OP_QUERY, 32'sd3);
    issue_request(blle_pkg::OP_QUERY, 32'sd12345);
    issue_request(blle_pkg::OP_DELETE, 32'sd7);
    issue_request(blle_pkg::OP_DELETE, -32'sd1);
    issue_request(blle_pkg::OP_DELETE, 32'sd3);
    issue_request(blle_pkg::OP_DELETE, 32'sd99);
    issue_request(blle_pkg::OP_POP_BACK, 32'sd0);
    issue_request(blle_pkg::OP_POP_FRONT, 32'sd0);

    wait_all_results();

    // fill to capacity, reject at full, deep walks
    while (tracker.entries.size() < blle_pkg::CAPACITY)
      issue_request($urandom_range(0, 1) ? blle_pkg::OP_PUSH_BACK : blle_pkg::OP_PUSH_FRONT,
                    pick_value());
    issue_request(blle_pkg::OP_PUSH_FRONT, pick_value());
    issue_request(blle_pkg::OP_PUSH_BACK, pick_value());
    issue_request(blle_pkg::OP_QUERY, tracker.entries[tracker.entries.size() - 1]);
    issue_request(blle_pkg::OP_DELETE, tracker.entries[tracker.entries.size() - 1]);
    issue_request(blle_pkg::OP_POP_BACK, $urandom);

    for (int phase = 0; phase < PHASES; phase++) begin
      gaps_on = (phase < PHASES - 1) && ($urandom_range(0, 3) != 0);
      repeat (PHASE_ITEMS) random_request((phase + 1) % 3);
      if ($urandom_range(0, 1)) wait_all_results();
    end

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.outstanding.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
